### rtl/bounded_priority_queue_evict_assert.svh
// Assertion macros used by the checker of the bounded priority queue.
`ifndef BOUNDED_PRIORITY_QUEUE_EVICT_ASSERT_SVH
`define BOUNDED_PRIORITY_QUEUE_EVICT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BPQE_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpqe: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BPQE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpqe: next-cycle check failed");

`endif

### rtl/bpqe_pkg.sv
// Package with the widths and request codes of the bounded priority queue.
`default_nettype none

package bpqe_pkg;

   localparam int DATA_W = 64;
   localparam int PRIO_W = 8;
   localparam int FILL_W = 3;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

endpackage

`default_nettype wire

### rtl/bpqe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module bpqe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the address written in the same cycle returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/bounded_priority_queue_evict.sv
// Top level of the bounded priority queue with eviction of the lowest entry.
// A push spends a read and a check on each list node it visits, an extra link step when it
// links behind a stored entry, and waits in DECIDE while the free slot search lags. A pop
// of an empty queue goes straight to RESP; a stalled result holds the sequencer.
// Synchronous reset empties the queue, not the slot RAMs.
`default_nettype none

module bounded_priority_queue_evict
   import bpqe_pkg::*;
#(
   parameter int QUEUE_DEPTH  = 4,
   parameter int PAYLOAD_BITS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_type,
   input  wire logic [PRIO_W-1:0] req_priority_req,
   input  wire logic [DATA_W-1:0] req_payload,

   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_ok,
   output logic                   rsp_counted_new,
   output logic                   rsp_evicted,
   output logic      [DATA_W-1:0] rsp_out_payload,
   output logic      [PRIO_W-1:0] rsp_out_priority,
   output logic      [FILL_W-1:0] rsp_fill_count
);

   // Slot index width and entry count width.
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   // The sequencer. A push walks the list from the head past every entry of equal or
   // higher priority (WALK_RD / WALK_CHK), then decides between a free slot, an eviction
   // and a rejection. An eviction walks on to the tail (TAIL_RD / TAIL_CHK). LINK writes
   // the new entry and LINK_PREV patches the link of its predecessor. RESP hands the
   // finished result to the output register as soon as that register is free.
   typedef enum logic [3:0] {
      S_IDLE,
      S_WALK_RD,
      S_WALK_CHK,
      S_DECIDE,
      S_TAIL_RD,
      S_TAIL_CHK,
      S_LINK,
      S_LINK_PREV,
      S_POP,
      S_RESP
   } state_type;

   state_type state_ff;

   // List bookkeeping. Link words, priorities and payloads live in RAMs; the valid bits
   // that reset must clear live in flip-flops.
   logic [IDX_W-1:0]       head_ff;
   logic                   head_valid_ff;
   logic [QUEUE_DEPTH-1:0] next_valid_ff;
   logic [QUEUE_DEPTH-1:0] in_use_ff;
   logic [CNT_W-1:0]       count_ff;

   // The request being worked on.
   logic [PRIO_W-1:0]       req_prio_ff;
   logic [PAYLOAD_BITS-1:0] req_data_ff;

   // Walk pointers. cur_ff is the node under inspection; during the eviction walk it
   // follows the tail. before_ff is the node the new entry goes behind.
   logic [IDX_W-1:0] cur_ff;
   logic             cur_valid_ff;
   logic [IDX_W-1:0] before_ff;
   logic             before_valid_ff;
   logic [IDX_W-1:0] tail_prev_ff;
   logic             tail_prev_valid_ff;
   logic             moved_ff;
   logic             evict_ff;
   logic [IDX_W-1:0] link_next_ff;
   logic             link_next_valid_ff;

   // Free slot search, one slot per cycle from slot zero, running beside the walk.
   logic [IDX_W-1:0] scan_ff;
   logic [IDX_W-1:0] free_ff;
   logic             free_found_ff;

   // Result under construction.
   logic                    res_ok_ff;
   logic                    res_new_ff;
   logic                    res_evict_ff;
   logic [PRIO_W-1:0]       res_prio_ff;
   logic [PAYLOAD_BITS-1:0] res_data_ff;

   // Output register.
   logic              rsp_valid_ff;
   logic              rsp_ok_ff;
   logic              rsp_new_ff;
   logic              rsp_evict_ff;
   logic [DATA_W-1:0] rsp_payload_ff;
   logic [PRIO_W-1:0] rsp_prio_ff;
   logic [FILL_W-1:0] rsp_fill_ff;

   // RAM ports.
   logic [IDX_W-1:0]        node_rd_addr;
   logic [IDX_W-1:0]        slot;
   logic [PRIO_W-1:0]       prio_rd;
   logic [IDX_W-1:0]        next_rd;
   logic [PAYLOAD_BITS-1:0] data_rd;
   logic                    link_wr;
   logic                    next_wr;
   logic [IDX_W-1:0]        next_wr_addr;
   logic [IDX_W-1:0]        next_wr_data;

   logic                    queue_full;
   logic                    rsp_free;
   logic [CNT_W+FILL_W-1:0] count_ext;
   logic [PAYLOAD_BITS+DATA_W-1:0] data_ext;

   assign queue_full = (count_ff == FULL_COUNT);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign count_ext  = {{FILL_W{1'b0}}, count_ff};
   assign data_ext   = {{DATA_W{1'b0}}, res_data_ff};

   // The new entry takes the tail's slot on an eviction and the free slot otherwise.
   assign slot = evict_ff ? cur_ff : free_ff;

   // While idle the node RAMs read at the head, so a pop has its data in the cycle after
   // the transfer. Otherwise they read at the walk pointer.
   assign node_rd_addr = (state_ff == S_IDLE) ? head_ff : cur_ff;

   // The link RAM is written twice for a push behind an existing entry: first the link of
   // the new entry, then the link of its predecessor.
   assign link_wr      = (state_ff == S_LINK);
   assign next_wr      = link_wr || (state_ff == S_LINK_PREV);
   assign next_wr_addr = link_wr ? slot : before_ff;
   assign next_wr_data = link_wr ? link_next_ff : slot;

   bpqe_ram #(
      .WIDTH (PRIO_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_prio_ram (
      .clock   (clock),
      .wr_en   (link_wr),
      .wr_addr (slot),
      .wr_data (req_prio_ff),
      .rd_addr (node_rd_addr),
      .rd_data (prio_rd)
   );

   bpqe_ram #(
      .WIDTH (IDX_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (next_wr),
      .wr_addr (next_wr_addr),
      .wr_data (next_wr_data),
      .rd_addr (node_rd_addr),
      .rd_data (next_rd)
   );

   bpqe_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (link_wr),
      .wr_addr (slot),
      .wr_data (req_data_ff),
      .rd_addr (head_ff),
      .rd_data (data_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         head_valid_ff <= 1'b0;
         next_valid_ff <= '0;
         in_use_ff     <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // The output register empties when its transfer completes, unless a new result
         // moves in at the same edge.
         if (rsp_valid_ff && !rsp_stall && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end

         // The free slot search. While the queue is not full some slot at or above the
         // scan position is free, so the scan never runs past the last slot.
         if (state_ff != S_IDLE && !free_found_ff && !queue_full) begin
            if (!in_use_ff[scan_ff]) begin
               free_ff       <= scan_ff;
               free_found_ff <= 1'b1;
            end else begin
               scan_ff <= scan_ff + 1'b1;
            end
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  res_ok_ff     <= 1'b0;
                  res_new_ff    <= 1'b0;
                  res_evict_ff  <= 1'b0;
                  res_prio_ff   <= '0;
                  res_data_ff   <= '0;
                  req_prio_ff   <= req_priority_req;
                  req_data_ff   <= req_payload[PAYLOAD_BITS-1:0];
                  scan_ff       <= '0;
                  free_found_ff <= 1'b0;
                  case (req_type)
                     REQ_PUSH: begin
                        cur_ff          <= head_ff;
                        cur_valid_ff    <= head_valid_ff;
                        before_valid_ff <= 1'b0;
                        state_ff        <= S_WALK_RD;
                     end
                     REQ_POP: begin
                        // A pop of an empty queue answers at once with ok clear.
                        state_ff <= head_valid_ff ? S_POP : S_RESP;
                     end
                     default: begin
                        state_ff <= S_RESP;
                     end
                  endcase
               end
            end

            S_WALK_RD: begin
               state_ff <= cur_valid_ff ? S_WALK_CHK : S_DECIDE;
            end

            S_WALK_CHK: begin
               // Equal priorities keep arrival order, so the walk passes them too.
               if (prio_rd >= req_prio_ff) begin
                  before_ff       <= cur_ff;
                  before_valid_ff <= 1'b1;
                  cur_ff          <= next_rd;
                  cur_valid_ff    <= next_valid_ff[cur_ff];
                  state_ff        <= S_WALK_RD;
               end else begin
                  state_ff <= S_DECIDE;
               end
            end

            S_DECIDE: begin
               // The node where the walk stopped follows the new entry.
               link_next_ff       <= cur_ff;
               link_next_valid_ff <= cur_valid_ff;
               if (free_found_ff) begin
                  evict_ff <= 1'b0;
                  state_ff <= S_LINK;
               end else if (!queue_full) begin
                  state_ff <= S_DECIDE;
               end else if (cur_valid_ff) begin
                  // Full, but a stored entry has a lower priority: the tail goes.
                  evict_ff           <= 1'b1;
                  tail_prev_ff       <= before_ff;
                  tail_prev_valid_ff <= before_valid_ff;
                  moved_ff           <= 1'b0;
                  state_ff           <= S_TAIL_RD;
               end else begin
                  // Full and nothing lower: the push is rejected, the queue is unchanged.
                  state_ff <= S_RESP;
               end
            end

            S_TAIL_RD: begin
               state_ff <= next_valid_ff[cur_ff] ? S_TAIL_CHK : S_LINK;
            end

            S_TAIL_CHK: begin
               tail_prev_ff       <= cur_ff;
               tail_prev_valid_ff <= 1'b1;
               cur_ff             <= next_rd;
               moved_ff           <= 1'b1;
               state_ff           <= S_TAIL_RD;
            end

            S_LINK: begin
               // Unlink the evicted tail first; a relink below may set the bit again.
               // When the tail was the head, the new entry becomes the head anyway.
               if (evict_ff && tail_prev_valid_ff) begin
                  next_valid_ff[tail_prev_ff] <= 1'b0;
               end
               // When the tail sat right behind the insertion point, the new entry
               // becomes the tail itself.
               next_valid_ff[slot] <= link_next_valid_ff && !(evict_ff && !moved_ff);
               in_use_ff[slot]     <= 1'b1;
               if (!evict_ff) begin
                  count_ff <= count_ff + 1'b1;
               end
               res_ok_ff    <= 1'b1;
               res_new_ff   <= !evict_ff;
               res_evict_ff <= evict_ff;
               if (before_valid_ff) begin
                  state_ff <= S_LINK_PREV;
               end else begin
                  head_ff       <= slot;
                  head_valid_ff <= 1'b1;
                  state_ff      <= S_RESP;
               end
            end

            S_LINK_PREV: begin
               next_valid_ff[before_ff] <= 1'b1;
               state_ff                 <= S_RESP;
            end

            S_POP: begin
               res_ok_ff          <= 1'b1;
               res_prio_ff        <= prio_rd;
               res_data_ff        <= data_rd;
               in_use_ff[head_ff] <= 1'b0;
               count_ff           <= count_ff - 1'b1;
               if (next_valid_ff[head_ff]) begin
                  head_ff <= next_rd;
               end else begin
                  head_valid_ff <= 1'b0;
               end
               state_ff <= S_RESP;
            end

            S_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_ok_ff      <= res_ok_ff;
                  rsp_new_ff     <= res_new_ff;
                  rsp_evict_ff   <= res_evict_ff;
                  rsp_payload_ff <= data_ext[DATA_W-1:0];
                  rsp_prio_ff    <= res_prio_ff;
                  rsp_fill_ff    <= count_ext[FILL_W-1:0];
                  state_ff       <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // A new request is taken only while the sequencer is idle; a result still waiting in
   // the output register does not hold it up.
   assign req_stall = (state_ff != S_IDLE);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_counted_new  = rsp_new_ff;
   assign rsp_evicted      = rsp_evict_ff;
   assign rsp_out_payload  = rsp_payload_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_fill_count   = rsp_fill_ff;

endmodule

`default_nettype wire

### rtl/bpqe_checker.sv
// Port checker of the bounded priority queue and its bind to the top level.
`default_nettype none

`include "bounded_priority_queue_evict_assert.svh"

module bpqe_checker
   import bpqe_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              req_type,
   input wire logic [PRIO_W-1:0] req_priority_req,
   input wire logic [DATA_W-1:0] req_payload,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic              rsp_ok,
   input wire logic              rsp_counted_new,
   input wire logic              rsp_evicted,
   input wire logic [DATA_W-1:0] rsp_out_payload,
   input wire logic [PRIO_W-1:0] rsp_out_priority,
   input wire logic [FILL_W-1:0] rsp_fill_count
);

   // A held result keeps all of its fields.
   `BPQE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_ok) && $stable(rsp_counted_new) && $stable(rsp_evicted) && $stable(rsp_out_payload) && $stable(rsp_out_priority) && $stable(rsp_fill_count))

   // A refused push or an empty pop carries nothing but the fill count.
   `BPQE_ASSERT_IMPL(a_fail_clean, clock, reset, rsp_valid && !rsp_ok, !rsp_counted_new && !rsp_evicted && rsp_out_payload == '0 && rsp_out_priority == '0)

   // A push either took a free slot or evicted, never both, and was then accepted.
   `BPQE_ASSERT_IMPL(a_push_kind, clock, reset, rsp_valid && (rsp_counted_new || rsp_evicted), rsp_ok && !(rsp_counted_new && rsp_evicted) && rsp_out_payload == '0)

   // The queue works on one request at a time.
   `BPQE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

endmodule

bind bounded_priority_queue_evict bpqe_checker u_bpqe_checker (.*);

`default_nettype wire
